@@ sv/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and constants of the relocation stream parser
// Holds register indexes, table constants, the result and configuration records.
// ----------------------------------------------------------------------------
package rsp_pkg;

	localparam int HALF_W = 16;
	localparam int WORD_W = 32;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ZERO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_OFFSET = 2'd2;

	// table constants
	localparam logic [WORD_W-1:0] START_POSITION = 32'd12;
	localparam logic [WORD_W-1:0] FAR_ENTRY_TOGGLE = 32'h8000_8000;
	localparam logic [WORD_W+1:0] END_MARGIN = 34'd6;

	typedef struct packed {
		logic [WORD_W-1:0] target_offset;
		logic [WORD_W-1:0] addend;
		logic write_valid;
		logic is_last;
	} result_t;

	typedef struct packed {
		logic [WORD_W-1:0] base_zero;
		logic [WORD_W-1:0] base_one;
		logic [WORD_W-1:0] end_offset;
	} cfg_t;

endpackage

@@ sv/relocation_stream_parser.sv @@
// ----------------------------------------------------------------------------
// relocation_stream_parser: streaming relocation table parser
// Turns table halfwords into patch items (offset, addend) for a consumer.
// ----------------------------------------------------------------------------
// Feed the table halfwords from byte 12 onward, one per item. The block takes
// one item per clock cycle while the output keeps moving. A patch reaches the
// output through the input register, which holds its last halfword, and the
// result register, loaded from the decode when the item is taken. A stalled
// output holds the input back. Halfwords that complete no entry (counts,
// far-entry low halves, ids, padding) give no result, save a zero count at the
// end. The final result has tlast set; everything after it is accepted
// and dropped. Write base_zero, base_one and end_offset before the first item.
module relocation_stream_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsp_pkg::WORD_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] halfword
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata,   // [31:0] target_offset, [63:32] addend
	output logic                        m_tuser,   // [0] write_valid
	output logic                        m_tlast    // is_last
);
	import rsp_pkg::*;

	cfg_t cfg_q;
	logic in_valid_s1;
	logic [HALF_W-1:0] in_half_s1;
	logic take;
	logic has_result;
	result_t core_result;
	logic out_free;
	result_t out_result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ZERO: cfg_q.base_zero <= cfg_data;
				REG_BASE_ONE: cfg_q.base_one <= cfg_data;
				REG_END_OFFSET: cfg_q.end_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: advance when the decode takes the held item
	assign take = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_half_s1 <= s_tdata[HALF_W-1:0];
		end
	end

	rsp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.halfword      (in_half_s1),
		.cfg           (cfg_q),
		.base_zero_we  (cfg_we && cfg_index == REG_BASE_ZERO),
		.base_zero_data(cfg_data),
		.has_result    (has_result),
		.result        (core_result)
	);

	rsp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.load_valid (has_result),
		.load_result(core_result),
		.m_ready    (m_tready),
		.free       (out_free),
		.m_valid    (m_tvalid),
		.m_result   (out_result)
	);

	// pack the result item
	assign m_tdata = {out_result.addend, out_result.target_offset};
	assign m_tuser = out_result.write_valid;
	assign m_tlast = out_result.is_last;

endmodule

@@ sv/rsp_core.sv @@
// ----------------------------------------------------------------------------
// rsp_core: parse state and per-halfword decode
// Holds the parser state and works out the next state and the result of
// one halfword combinationally; state commits when the item is taken.
// ----------------------------------------------------------------------------
module rsp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [rsp_pkg::HALF_W-1:0] halfword,
	input  rsp_pkg::cfg_t          cfg,
	input  logic                   base_zero_we,
	input  logic [rsp_pkg::WORD_W-1:0] base_zero_data,
	output logic                   has_result,
	output rsp_pkg::result_t       result
);
	import rsp_pkg::*;

	// parse phase codes
	localparam logic [PHASE_W-1:0] PH_COUNT = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ENTRY = 3'd1;
	localparam logic [PHASE_W-1:0] PH_WORD_LOW = 3'd2;
	localparam logic [PHASE_W-1:0] PH_WORD_HIGH = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ID_PAD = 3'd4;
	localparam logic [PHASE_W-1:0] PH_ID_LOW = 3'd5;
	localparam logic [PHASE_W-1:0] PH_ID_HIGH = 3'd6;
	localparam logic [PHASE_W-1:0] PH_DONE = 3'd7;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [WORD_W-1:0] pos_q, pos_d;
	logic [HALF_W-1:0] left_q, left_d;
	logic [WORD_W-1:0] roff_q, roff_d;
	logic [WORD_W-1:0] base_q, base_d;
	logic [HALF_W-1:0] held_q, held_d;
	logic started_q;

	// group close: align to 4 bytes, compare without wrap
	logic [WORD_W-1:0] pos_next;
	logic [1:0] pad;
	logic [WORD_W+1:0] aligned_end;
	logic group_ends;
	logic [PHASE_W-1:0] after_group;
	logic [WORD_W-1:0] word_in;
	logic [HALF_W-1:0] left_dec;

	assign pos_next = pos_q + WORD_W'(2);
	assign pad = {pos_next[1], 1'b0};
	assign aligned_end = {2'b00, pos_next} + {{WORD_W{1'b0}}, pad} + END_MARGIN;
	assign group_ends = aligned_end >= {2'b00, cfg.end_offset};
	assign after_group = group_ends ? PH_DONE : (pad[1] ? PH_ID_PAD : PH_ID_LOW);
	assign word_in = {halfword, held_q};
	assign left_dec = left_q - HALF_W'(1);

	// decode one halfword
	always_comb begin
		phase_d = phase_q;
		pos_d = pos_next;
		left_d = left_q;
		roff_d = roff_q;
		base_d = base_q;
		held_d = held_q;
		has_result = 1'b0;
		result.target_offset = roff_q;
		result.addend = base_q;
		result.write_valid = 1'b1;
		result.is_last = 1'b0;
		unique case (phase_q)
			PH_COUNT: begin
				roff_d = '0;
				left_d = halfword;
				if (halfword == '0) begin
					phase_d = after_group;
					if (group_ends) begin
						has_result = 1'b1;
						result.target_offset = '0;
						result.addend = '0;
						result.write_valid = 1'b0;
						result.is_last = 1'b1;
					end
				end else begin
					phase_d = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				if (halfword[HALF_W-1]) begin
					if (pos_q[1]) begin
						phase_d = PH_WORD_LOW;
					end else begin
						held_d = halfword;
						phase_d = PH_WORD_HIGH;
					end
				end else begin
					roff_d = roff_q + {{(WORD_W-HALF_W-2){1'b0}}, halfword, 2'b00};
					has_result = 1'b1;
				end
			end
			PH_WORD_LOW: begin
				held_d = halfword;
				phase_d = PH_WORD_HIGH;
			end
			PH_WORD_HIGH: begin
				roff_d = word_in[WORD_W-1] ? (word_in ^ FAR_ENTRY_TOGGLE) : word_in;
				has_result = 1'b1;
			end
			PH_ID_PAD: begin
				phase_d = PH_ID_LOW;
			end
			PH_ID_LOW: begin
				held_d = halfword;
				phase_d = PH_ID_HIGH;
			end
			PH_ID_HIGH: begin
				if (word_in == WORD_W'(0)) begin
					base_d = cfg.base_zero;
				end else if (word_in == WORD_W'(1)) begin
					base_d = cfg.base_one;
				end else begin
					base_d = '0;
				end
				phase_d = PH_COUNT;
			end
			PH_DONE: begin
				pos_d = pos_q;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		// patch emitted: count down and close the group on the last entry
		if (has_result && phase_q != PH_COUNT) begin
			result.target_offset = roff_d;
			left_d = left_dec;
			if (left_dec == '0) begin
				phase_d = after_group;
				result.is_last = group_ends;
			end else begin
				phase_d = PH_ENTRY;
			end
		end
	end

	// commit state on each taken item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pos_q <= START_POSITION;
			left_q <= '0;
			roff_q <= '0;
			base_q <= '0;
			held_q <= '0;
			started_q <= 1'b0;
		end else if (take) begin
			if (phase_q != PH_DONE) begin
				started_q <= 1'b1;
			end
			phase_q <= phase_d;
			pos_q <= pos_d;
			left_q <= left_d;
			roff_q <= roff_d;
			base_q <= base_d;
			held_q <= held_d;
		end else if (base_zero_we && !started_q) begin
			base_q <= base_zero_data;
		end
	end

endmodule

@@ sv/rsp_out_stage.sv @@
// ----------------------------------------------------------------------------
// rsp_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module rsp_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             load_valid,
	input  rsp_pkg::result_t load_result,
	input  logic             m_ready,
	output logic             free,
	output logic             m_valid,
	output rsp_pkg::result_t m_result
);
	import rsp_pkg::*;

	logic valid_q;
	result_t res_q;

	assign free = !valid_q || m_ready;
	assign m_valid = valid_q;
	assign m_result = res_q;

	// load a new result or drop the delivered one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_q <= load_result;
		end
	end

endmodule
